/* design/slpd_pkg.sv */
// Shared constants and types for the sync/length packet deframer.
package slpd_pkg;

  localparam int BUF_DEPTH = 8192;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CUR_W     = BUF_AW + 1;
  localparam int LEN_W     = 16;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hBE;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hEF;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST,
    CFG_SYNC_SECOND
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_RX,
    REQ_LINE_ERR,
    REQ_RELEASE,
    REQ_READ
  } req_t;

  typedef enum logic [1:0] {
    EV_READY,
    EV_DROPPED,
    EV_BAD_FILL,
    EV_READ_DATA
  } event_t;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_FILL1,
    PH_FILL2,
    PH_FIRST,
    PH_PAYLOAD
  } phase_t;

endpackage

/* design/slpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module slpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/sync_length_packet_deframer_top.sv */
// Top level of the sync/length packet deframer: header parser, packet buffer, result register.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall   | req_type, rx_byte, release_start, release_len, read_addr
//   out_    | out | out_valid/out_stall | event_code, packet_start, packet_len, read_data
//   cfg_    | in  | cfg_we              | cfg_index, cfg_data
//
// One item per cycle while in_stall is low. Every item is decoded and the state updated
// in the cycle of its transfer; any result shows in the result register on the next cycle.
// Read data comes from the buffer RAM's registered read port, in line with the result register.
// Reset is synchronous; the buffer itself is not cleared.
// in_stall is high only while a result sits in the output register and out_stall is high.
module sync_length_packet_deframer_top
  import slpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic [12:0] in_release_start,
  input  logic [13:0] in_release_len,
  input  logic [12:0] in_read_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_code,
  output logic [12:0] out_packet_start,
  output logic [15:0] out_packet_len,
  output logic [7:0]  out_read_data
);

  logic [7:0]        sync_first_r, sync_second_r;
  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [BUF_AW-1:0] begin_r, begin_nxt;
  logic [CUR_W-1:0]  commit_r, commit_nxt;
  logic [CUR_W-1:0]  rd_idx_r, rd_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  event_t            out_code_r;
  logic [BUF_AW-1:0] out_start_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_read_r;

  logic              accept;
  req_t              req;
  logic              res_valid;
  event_t            res_code;
  logic [BUF_AW-1:0] res_start;
  logic [LEN_W-1:0]  res_len;
  logic              res_read;

  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_waddr;
  logic [7:0]        ram_q;

  logic [LEN_W-1:0]  len_full;
  logic [LEN_W:0]    space;
  logic [BUF_AW-1:0] cur_begin;
  logic              cur_in_range;
  logic [CUR_W-1:0]  cursor_inc;
  logic [LEN_W:0]    end_sum;
  logic [CUR_W:0]    rel_sum;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign req      = req_t'(in_req_type);

  assign len_full     = {in_rx_byte, len_r[7:0]};
  assign space        = (LEN_W + 1)'(BUF_DEPTH) - (LEN_W + 1)'(commit_r);
  assign cur_begin    = (phase_r == PH_FIRST) ? cursor_r[BUF_AW-1:0] : begin_r;
  assign cur_in_range = cursor_r < CUR_W'(BUF_DEPTH);
  assign cursor_inc   = cur_in_range ? cursor_r + CUR_W'(1) : cursor_r;
  assign end_sum      = (LEN_W + 1)'(cur_begin) + (LEN_W + 1)'(len_r);
  assign rel_sum      = (in_release_start == '0) ? (CUR_W + 1)'(in_release_len)
                        : (CUR_W + 1)'(rd_idx_r) + (CUR_W + 1)'(in_release_len);

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    cursor_nxt = cursor_r;
    begin_nxt  = begin_r;
    commit_nxt = commit_r;
    rd_idx_nxt = rd_idx_r;
    res_valid  = 1'b0;
    res_code   = EV_READY;
    res_start  = '0;
    res_len    = '0;
    res_read   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = cursor_r[BUF_AW-1:0];

    if (accept) begin
      case (req)
        REQ_RX: begin
          case (phase_r)
            PH_SYNC1: begin
              if (in_rx_byte == sync_first_r) phase_nxt = PH_SYNC2;
            end
            PH_SYNC2: begin
              phase_nxt = (in_rx_byte == sync_second_r) ? PH_LEN_LO : PH_SYNC1;
            end
            PH_LEN_LO: begin
              len_nxt   = {8'h00, in_rx_byte};
              phase_nxt = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              len_nxt = len_full;
              if (len_full > LEN_W'(BUF_DEPTH)) begin
                phase_nxt = PH_SYNC1;
                res_valid = 1'b1;
                res_code  = EV_DROPPED;
                res_len   = len_full;
              end else if (space < (LEN_W + 1)'(len_full)) begin
                if (LEN_W'(rd_idx_r) < len_full) begin
                  phase_nxt = PH_SYNC1;
                  res_valid = 1'b1;
                  res_code  = EV_DROPPED;
                  res_len   = len_full;
                end else begin
                  cursor_nxt = '0;
                  phase_nxt  = PH_FILL1;
                end
              end else begin
                cursor_nxt = commit_r;
                phase_nxt  = PH_FILL1;
              end
            end
            PH_FILL1, PH_FILL2: begin
              if (in_rx_byte != 8'h00) begin
                phase_nxt = PH_SYNC1;
                res_valid = 1'b1;
                res_code  = EV_BAD_FILL;
              end else if (phase_r == PH_FILL2 && len_r == '0) begin
                // empty packet completes on the second filler byte
                commit_nxt = cursor_r;
                phase_nxt  = PH_SYNC1;
                res_valid  = 1'b1;
                res_code   = EV_READY;
                res_start  = cur_in_range ? cursor_r[BUF_AW-1:0] : '0;
              end else begin
                phase_nxt = (phase_r == PH_FILL1) ? PH_FILL2 : PH_FIRST;
              end
            end
            PH_FIRST, PH_PAYLOAD: begin
              begin_nxt  = cur_begin;
              ram_we     = cur_in_range;
              cursor_nxt = cursor_inc;
              if ((LEN_W + 1)'(cursor_inc) >= end_sum) begin
                commit_nxt = cursor_inc;
                phase_nxt  = PH_SYNC1;
                res_valid  = 1'b1;
                res_code   = EV_READY;
                res_start  = cur_begin;
                res_len    = len_r;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
            default: phase_nxt = PH_SYNC1;
          endcase
        end
        REQ_LINE_ERR: phase_nxt = PH_SYNC1;
        REQ_RELEASE: begin
          if ((CUR_W)'(in_release_start) < CUR_W'(BUF_DEPTH)) begin
            rd_idx_nxt = (rel_sum > (CUR_W + 1)'(BUF_DEPTH)) ? CUR_W'(BUF_DEPTH)
                         : rel_sum[CUR_W-1:0];
          end
        end
        REQ_READ: begin
          ram_re    = 1'b1;
          res_valid = 1'b1;
          res_code  = EV_READ_DATA;
          res_read  = (CUR_W)'(in_read_addr) < CUR_W'(BUF_DEPTH);
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      phase_r       <= PH_SYNC1;
      len_r         <= '0;
      cursor_r      <= '0;
      begin_r       <= '0;
      commit_r      <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
          CFG_SYNC_SECOND: sync_second_r <= cfg_data;
          default:         sync_first_r  <= sync_first_r;
        endcase
      end
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      cursor_r    <= cursor_nxt;
      begin_r     <= begin_nxt;
      commit_r    <= commit_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_code_r  <= res_code;
      out_start_r <= res_start;
      out_len_r   <= res_len;
      out_read_r  <= res_read;
    end
  end

  slpd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (in_read_addr[BUF_AW-1:0]),
    .rdata (ram_q)
  );

  assign out_valid        = out_valid_r;
  assign out_event_code   = out_code_r;
  assign out_packet_start = out_start_r;
  assign out_packet_len   = out_len_r;
  assign out_read_data    = out_read_r ? ram_q : 8'h00;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  a_commit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    commit_r <= CUR_W'(BUF_DEPTH))
    else $error("committed write index beyond buffer");

  a_read_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= CUR_W'(BUF_DEPTH))
    else $error("read index beyond buffer");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req == REQ_READ |=> out_valid_r && out_code_r == EV_READ_DATA)
    else $error("read transfer gave no read result");
`endif

endmodule

/* tb/deframer_checker.sv */
// Checker for the packet deframer: follows every transfer, predicts each result and compares it.
`timescale 1ns / 100ps
module deframer_checker
  import slpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [7:0]           in_rx_byte,
  input  logic [12:0]          in_release_start,
  input  logic [13:0]          in_release_len,
  input  logic [12:0]          in_read_addr,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_event_code,
  input  logic [12:0]          out_packet_start,
  input  logic [15:0]          out_packet_len,
  input  logic [7:0]           out_read_data,
  output int                   errors,
  output int                   pending,
  output logic [BUF_DEPTH-1:0] stored_map
);

  typedef struct packed {
    event_t            code;
    logic [BUF_AW-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
  } deframe_event_t;

  deframe_event_t    due_events[$];
  deframe_event_t    head_ev;
  phase_t            ph;
  logic [7:0]        sync1_q;
  logic [7:0]        sync2_q;
  logic [LEN_W-1:0]  hdr_len;
  logic [CUR_W-1:0]  wr_cur;
  logic [CUR_W-1:0]  commit_idx;
  logic [CUR_W-1:0]  rd_idx;
  logic [BUF_AW-1:0] pkt_begin;
  logic [7:0]        store_mem [BUF_DEPTH];
  int unsigned       nxt_idx;

  function automatic int field_bad(string fname, logic [15:0] want, logic [15:0] got);
    if (got === want) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    return 1;
  endfunction

  task automatic take_payload(input logic [7:0] b);
    if (wr_cur < BUF_DEPTH) begin
      store_mem[wr_cur[BUF_AW-1:0]] = b;
      stored_map[wr_cur[BUF_AW-1:0]] = 1'b1;
      wr_cur = wr_cur + 1'b1;
    end
    if (wr_cur >= pkt_begin + hdr_len) begin
      commit_idx = wr_cur;
      ph = PH_SYNC1;
      due_events.push_back('{EV_READY, pkt_begin, hdr_len, 8'd0});
    end else begin
      ph = PH_PAYLOAD;
    end
  endtask

  task automatic deframe_rx(input logic [7:0] b);
    case (ph)
      PH_SYNC1: if (b == sync1_q) ph = PH_SYNC2;
      PH_SYNC2: ph = (b == sync2_q) ? PH_LEN_LO : PH_SYNC1;
      PH_LEN_LO: begin
        hdr_len = {8'd0, b};
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        hdr_len[15:8] = b;
        if (hdr_len > BUF_DEPTH) begin
          ph = PH_SYNC1;
          due_events.push_back('{EV_DROPPED, '0, hdr_len, 8'd0});
        end else if (BUF_DEPTH - commit_idx < hdr_len) begin
          // no room at the end: wrap to the start if the reader has moved past it
          if (rd_idx < hdr_len) begin
            ph = PH_SYNC1;
            due_events.push_back('{EV_DROPPED, '0, hdr_len, 8'd0});
          end else begin
            wr_cur = '0;
            ph = PH_FILL1;
          end
        end else begin
          wr_cur = commit_idx;
          ph = PH_FILL1;
        end
      end
      PH_FILL1, PH_FILL2: begin
        if (b != 8'd0) begin
          ph = PH_SYNC1;
          due_events.push_back('{EV_BAD_FILL, '0, '0, 8'd0});
        end else if (ph == PH_FILL2 && hdr_len == '0) begin
          commit_idx = wr_cur;
          ph = PH_SYNC1;
          due_events.push_back('{EV_READY,
                                 (wr_cur >= BUF_DEPTH) ? '0 : wr_cur[BUF_AW-1:0],
                                 '0, 8'd0});
        end else begin
          ph = (ph == PH_FILL1) ? PH_FILL2 : PH_FIRST;
        end
      end
      PH_FIRST: begin
        pkt_begin = wr_cur[BUF_AW-1:0];
        take_payload(b);
      end
      default: take_payload(b);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph         = PH_SYNC1;
      sync1_q    = SYNC_FIRST_RST;
      sync2_q    = SYNC_SECOND_RST;
      hdr_len    = '0;
      wr_cur     = '0;
      commit_idx = '0;
      rd_idx     = '0;
      pkt_begin  = '0;
      stored_map = '0;
      errors     = 0;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_index) == CFG_SYNC_FIRST) sync1_q = cfg_data;
        else sync2_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: result transfer, expected none, actual code %0d", $time,
                   out_event_code);
        end else begin
          head_ev = due_events.pop_front();
          errors += field_bad("event_code", head_ev.code, out_event_code);
          errors += field_bad("packet_start", head_ev.start, out_packet_start);
          errors += field_bad("packet_len", head_ev.len, out_packet_len);
          errors += field_bad("read_data", head_ev.data, out_read_data);
        end
      end
      if (in_valid && !in_stall) begin
        case (req_t'(in_req_type))
          REQ_RX:       deframe_rx(in_rx_byte);
          REQ_LINE_ERR: ph = PH_SYNC1;
          REQ_RELEASE: begin
            nxt_idx = (in_release_start == '0) ? in_release_len : rd_idx + in_release_len;
            rd_idx  = (nxt_idx > BUF_DEPTH) ? CUR_W'(BUF_DEPTH) : CUR_W'(nxt_idx);
          end
          default: due_events.push_back('{EV_READ_DATA, '0, '0, store_mem[in_read_addr]});
        endcase
      end
    end
    pending = due_events.size();
  end

endmodule

/* tb/tb_sync_length_packet_deframer_top.sv */
// Testbench top for the packet deframer: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_sync_length_packet_deframer_top;
  import slpd_pkg::*;

  localparam int HOLD_CYCLES = 80;

  bit                   clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [0:0]           cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_req_type;
  logic [7:0]           in_rx_byte;
  logic [12:0]          in_release_start;
  logic [13:0]          in_release_len;
  logic [12:0]          in_read_addr;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_event_code;
  logic [12:0]          out_packet_start;
  logic [15:0]          out_packet_len;
  logic [7:0]           out_read_data;
  int                   check_errors;
  int                   due_count;
  logic [BUF_DEPTH-1:0] stored_map;
  int                   snd_idle_pct;
  int                   rcv_stall_pct;
  int                   hold_asked;
  logic [7:0]           cur_sync1;
  logic [7:0]           cur_sync2;

  sync_length_packet_deframer_top dut (.*);

  deframer_checker chk (.*, .errors(check_errors), .pending(due_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_served < hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  function automatic bit pick_stored_addr(output logic [12:0] addr);
    int base;
    base = $urandom_range(BUF_DEPTH - 1);
    for (int k = 0; k < BUF_DEPTH; k++) begin
      if (stored_map[(base + k) % BUF_DEPTH]) begin
        addr = 13'((base + k) % BUF_DEPTH);
        return 1'b1;
      end
    end
    addr = '0;
    return 1'b0;
  endfunction

  function automatic logic [12:0] rand_rel_start();
    return ($urandom_range(3) == 0) ? 13'd0 : 13'($urandom_range(1, BUF_DEPTH - 1));
  endfunction

  function automatic logic [13:0] rand_rel_len();
    case ($urandom_range(9))
      0:       return 14'(BUF_DEPTH);
      1, 2:    return 14'($urandom_range(BUF_DEPTH));
      default: return 14'($urandom_range(64));
    endcase
  endfunction

  // one transfer; fields the request does not use carry random values
  task automatic send_item(req_t req, logic [7:0] rx, logic [12:0] rs, logic [13:0] rl);
    logic [12:0] addr;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    addr = 13'($urandom);
    if (req == REQ_READ && !pick_stored_addr(addr)) req = REQ_RELEASE;
    in_valid         = 1'b1;
    in_req_type      = req;
    in_rx_byte       = (req == REQ_RX) ? rx : 8'($urandom);
    in_release_start = (req == REQ_RELEASE) ? rs : 13'($urandom);
    in_release_len   = (req == REQ_RELEASE) ? rl : 14'($urandom_range(BUF_DEPTH));
    in_read_addr     = addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_RX, b, '0, '0);
  endtask

  task automatic send_line_err();
    send_item(REQ_LINE_ERR, '0, '0, '0);
  endtask

  task automatic send_read();
    send_item(REQ_READ, '0, rand_rel_start(), rand_rel_len());
  endtask

  task automatic send_header(logic [15:0] len);
    send_byte(cur_sync1);
    send_byte(cur_sync2);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_packet(int len);
    send_header(16'(len));
    send_byte(8'd0);
    send_byte(8'd0);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_sync(logic [7:0] first, logic [7:0] second);
    settle();
    cfg_we    = 1'b1;
    cfg_index = CFG_SYNC_FIRST;
    cfg_data  = first;
    @(negedge clk);
    cfg_index = CFG_SYNC_SECOND;
    cfg_data  = second;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_sync1 = first;
    cur_sync2 = second;
  endtask

  // receiver holds off while reads keep coming, so the output register fills and blocks input
  task automatic hold_and_flood();
    hold_asked++;
    repeat (12) begin
      send_read();
      send_byte(8'($urandom));
    end
  endtask

  task automatic run_random(int n_items);
    int done;
    int pick;
    int len;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(1) == 1) send_line_err();
        len = ($urandom_range(19) == 0) ? $urandom_range(300, 13) : $urandom_range(12);
        send_packet(len);
        done += len + 6;
      end else if (pick < 60) begin
        send_line_err();
        case ($urandom_range(3))
          0: begin
            send_header(16'($urandom_range(8)));
            if ($urandom_range(1) == 1) send_byte(8'd0);
            send_byte(8'($urandom_range(255, 1)));
            done += 6;
          end
          1: begin
            send_header({8'($urandom_range(255, 33)), 8'($urandom)});
            done += 4;
          end
          2: begin
            len = $urandom_range(20, 2);
            send_header(16'(len));
            send_byte(8'd0);
            send_byte(8'd0);
            repeat ($urandom_range(len - 1)) send_byte(8'($urandom));
            send_line_err();
            done += len + 4;
          end
          default: begin
            send_byte(cur_sync1);
            send_byte(cur_sync2 ^ 8'($urandom_range(255, 1)));
            done += 2;
          end
        endcase
      end else if (pick < 78) begin
        send_read();
        done++;
      end else if (pick < 88) begin
        send_item(REQ_RELEASE, '0, rand_rel_start(), rand_rel_len());
        done++;
      end else if ($urandom_range(1) == 1) begin
        send_byte(8'($urandom));
      end else begin
        send_line_err();
      end
    end
  endtask

  initial begin
    int ph_i;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SYNC_FIRST;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_RX;
    in_rx_byte       = '0;
    in_release_start = '0;
    in_release_len   = '0;
    in_read_addr     = '0;
    snd_idle_pct     = 0;
    rcv_stall_pct    = 0;
    hold_asked       = 0;
    cur_sync1        = SYNC_FIRST_RST;
    cur_sync2        = SYNC_SECOND_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero length, one byte, read back
    send_packet(0);
    send_header(16'd1);
    send_byte(8'd0);
    send_byte(8'd0);
    send_byte(8'hFF);
    send_read();
    // full-size packet with no room and the reader behind: dropped
    send_header(16'd8192);
    send_item(REQ_RELEASE, '0, 13'd0, 14'd8192);
    // same again with the reader at the end: wraps to the start, then a bad filler
    send_header(16'd8192);
    send_byte(8'h5A);
    send_byte(cur_sync1);
    send_line_err();
    send_header(16'hFFFF);

    // zero-length packet after the aborted wrap
    send_packet(0);

    for (ph_i = 0; ph_i < 4; ph_i++) begin
      case (ph_i)
        1: begin
          set_sync(8'h00, 8'hFF);
          snd_idle_pct  = 70;
          rcv_stall_pct = 0;
        end
        2: begin
          set_sync(8'hFF, 8'h00);
          snd_idle_pct  = 0;
          rcv_stall_pct = 70;
          hold_and_flood();
        end
        3: begin
          set_sync(8'($urandom), 8'($urandom));
          snd_idle_pct  = 38;
          rcv_stall_pct = 38;
        end
        default: hold_and_flood();
      endcase
      run_random(120);
    end

    settle();
    if (check_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/slpd_pkg.sv
design/slpd_ram.sv
design/sync_length_packet_deframer_top.sv
tb/deframer_checker.sv
tb/tb_sync_length_packet_deframer_top.sv
